[rtl/hsv_crossfade_pixel_engine_defines.svh]
`ifndef HSV_CROSSFADE_PIXEL_ENGINE_DEFINES_SVH
`define HSV_CROSSFADE_PIXEL_ENGINE_DEFINES_SVH

// same-cycle implication, off while reset is asserted
`define HCF_ASSERT_IMPL(LBL, CK, RN, ANTE, CONS, MSG) \
	LBL: assert property (@(posedge CK) disable iff (!RN) (ANTE) |-> (CONS)) \
		else $error(MSG);

// next-cycle implication, off while reset is asserted
`define HCF_ASSERT_NEXT(LBL, CK, RN, ANTE, CONS, MSG) \
	LBL: assert property (@(posedge CK) disable iff (!RN) (ANTE) |=> (CONS)) \
		else $error(MSG);

`endif

[rtl/hcf_pkg.sv]
package hcf_pkg;

	localparam int IDX_W   = 6;
	localparam int HUE_W   = 9;
	localparam int PCT_W   = 7;
	localparam int FRAME_W = 8;
	localparam int COLOR_W = 8;

	localparam int PIXEL_COUNT_DEF = 64;
	localparam int FADE_STEPS_DEF  = 32;
	localparam int QUEUE_DEPTH_DEF = 2;

	localparam int HUE_FULL   = 360;
	localparam int HUE_HALF   = 180;
	localparam int PCT_MAX    = 100;
	localparam int SECTOR_DEG = 60;

	// lerp arithmetic widths
	localparam int N_W        = 20;
	localparam int M_W        = 19;
	localparam int Q_W        = 18;
	localparam int RCP_W      = 20;
	localparam int RCP_SHIFT  = 20;

	// exact floor(x/100) for x < 43690, floor(x/60) for x < 23831
	localparam int DIV100_MUL   = 5243;
	localparam int DIV100_W     = 13;
	localparam int DIV100_SHIFT = 19;
	localparam int DIV60_MUL    = 17477;
	localparam int DIV60_W      = 15;
	localparam int DIV60_SHIFT  = 20;

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_TICK = 1'b1
	} hcf_op_t;

	// command passed from front to back through the queue
	typedef struct packed {
		hcf_op_t                 op;
		logic [IDX_W-1:0]        idx;
		logic [HUE_W-1:0]        s_hue;
		logic [PCT_W-1:0]        s_sat;
		logic [PCT_W-1:0]        s_val;
		logic signed [HUE_W-1:0] d_hue;
		logic signed [PCT_W:0]   d_sat;
		logic signed [PCT_W:0]   d_val;
		logic [FRAME_W-1:0]      frame;
	} hcf_cmd_t;

endpackage

[rtl/hcf_if.sv]
interface hcf_cmd_if import hcf_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               opcode;
	logic [IDX_W-1:0]   led_index;
	logic [HUE_W-1:0]   from_hue;
	logic [PCT_W-1:0]   from_sat;
	logic [PCT_W-1:0]   from_val;
	logic [HUE_W-1:0]   to_hue;
	logic [PCT_W-1:0]   to_sat;
	logic [PCT_W-1:0]   to_val;
	logic [FRAME_W-1:0] frame;

	modport source (
		output valid, opcode, led_index, from_hue, from_sat, from_val,
		output to_hue, to_sat, to_val, frame,
		input  ready
	);
	modport sink (
		input  valid, opcode, led_index, from_hue, from_sat, from_val,
		input  to_hue, to_sat, to_val, frame,
		output ready
	);
endinterface

interface hcf_pix_if import hcf_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [IDX_W-1:0]   pixel_index;
	logic [COLOR_W-1:0] red;
	logic [COLOR_W-1:0] green;
	logic [COLOR_W-1:0] blue;
	logic               last_pixel;

	modport source (
		output valid, pixel_index, red, green, blue, last_pixel,
		input  ready
	);
	modport sink (
		input  valid, pixel_index, red, green, blue, last_pixel,
		output ready
	);
endinterface

[rtl/hcf_ram.sv]
module hcf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end
endmodule

[rtl/hcf_queue.sv]
`include "hsv_crossfade_pixel_engine_defines.svh"

module hcf_queue import hcf_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  hcf_cmd_t push_data,
	output logic     full,
	input  logic     pop,
	output hcf_cmd_t pop_data,
	output logic     not_empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

	hcf_cmd_t      mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full      = (count_q == CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	`HCF_ASSERT_IMPL(a_push_not_full, clk, arst_n, push, !full, "queue written while full")
	`HCF_ASSERT_IMPL(a_pop_not_empty, clk, arst_n, pop, not_empty, "queue read while empty")
	`HCF_ASSERT_NEXT(a_push_holds, clk, arst_n, push && !pop, not_empty, "pushed item lost")
endmodule

[rtl/hcf_front.sv]
module hcf_front import hcf_pkg::*; #(
	parameter int PIXEL_COUNT = PIXEL_COUNT_DEF,
	parameter int FADE_STEPS  = FADE_STEPS_DEF
) (
	hcf_cmd_if.sink  cmd,
	output hcf_cmd_t q_data,
	output logic     q_push,
	input  logic     q_full
);
	logic [HUE_W-1:0]      fh;
	logic [HUE_W-1:0]      th;
	logic [PCT_W-1:0]      fs;
	logic [PCT_W-1:0]      ts;
	logic [PCT_W-1:0]      fv;
	logic [PCT_W-1:0]      tv;
	logic signed [HUE_W:0] dh;
	logic signed [HUE_W:0] dh_wrap;
	logic                  in_range;

	always_comb begin
		// hue into 0..359, percentages saturate at 100
		fh = (cmd.from_hue >= HUE_W'(HUE_FULL)) ? cmd.from_hue - HUE_W'(HUE_FULL) : cmd.from_hue;
		th = (cmd.to_hue >= HUE_W'(HUE_FULL)) ? cmd.to_hue - HUE_W'(HUE_FULL) : cmd.to_hue;
		fs = (cmd.from_sat > PCT_W'(PCT_MAX)) ? PCT_W'(PCT_MAX) : cmd.from_sat;
		ts = (cmd.to_sat > PCT_W'(PCT_MAX)) ? PCT_W'(PCT_MAX) : cmd.to_sat;
		fv = (cmd.from_val > PCT_W'(PCT_MAX)) ? PCT_W'(PCT_MAX) : cmd.from_val;
		tv = (cmd.to_val > PCT_W'(PCT_MAX)) ? PCT_W'(PCT_MAX) : cmd.to_val;

		// shortest way round, -180..179
		dh = $signed({1'b0, th}) - $signed({1'b0, fh});
		priority if (dh >= (HUE_W+1)'(HUE_HALF)) begin
			dh_wrap = dh - (HUE_W+1)'(HUE_FULL);
		end else if (dh < -(HUE_W+1)'(HUE_HALF)) begin
			dh_wrap = dh + (HUE_W+1)'(HUE_FULL);
		end else begin
			dh_wrap = dh;
		end

		q_data.op    = hcf_op_t'(cmd.opcode);
		q_data.idx   = cmd.led_index;
		q_data.s_hue = fh;
		q_data.s_sat = fs;
		q_data.s_val = fv;
		q_data.d_hue = dh_wrap[HUE_W-1:0];
		q_data.d_sat = $signed({1'b0, ts}) - $signed({1'b0, fs});
		q_data.d_val = $signed({1'b0, tv}) - $signed({1'b0, fv});
		q_data.frame = (cmd.frame > FRAME_W'(FADE_STEPS)) ? FRAME_W'(FADE_STEPS) : cmd.frame;

		in_range = ({1'b0, cmd.led_index} < (IDX_W+1)'(PIXEL_COUNT));
	end

	// loads beyond the strip are taken and dropped
	assign cmd.ready = !q_full;
	assign q_push    = cmd.valid && !q_full && ((q_data.op == OP_TICK) || in_range);
endmodule

[rtl/hcf_back.sv]
`include "hsv_crossfade_pixel_engine_defines.svh"

module hcf_back import hcf_pkg::*; #(
	parameter int PIXEL_COUNT = PIXEL_COUNT_DEF,
	parameter int FADE_STEPS  = FADE_STEPS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  hcf_cmd_t  q_data,
	input  logic      q_valid,
	output logic      q_pop,
	hcf_pix_if.source pixel
);
	localparam int AW     = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
	localparam int NSTAGE = 12;
	localparam int LANES  = 3;
	localparam int V255_W = 15;
	localparam int P_W    = 15;
	localparam int P2_W   = 14;
	localparam int HMOD_W = 6;
	localparam int TWO_F_W = FRAME_W + 1;
	localparam logic [IDX_W-1:0]   LAST_IDX = IDX_W'(PIXEL_COUNT - 1);
	localparam logic [RCP_W-1:0]   RCP      = RCP_W'((1 << (RCP_SHIFT - 1)) / FADE_STEPS);
	localparam logic [TWO_F_W-1:0] TWO_F    = TWO_F_W'(2 * FADE_STEPS);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_WALK = 2'b10
	} state_t;

	typedef enum logic [2:0] {
		SEC_RED_YEL = 3'd0,
		SEC_YEL_GRN = 3'd1,
		SEC_GRN_CYN = 3'd2,
		SEC_CYN_BLU = 3'd3,
		SEC_BLU_MAG = 3'd4,
		SEC_MAG_RED = 3'd5
	} sector_t;

	typedef struct packed {
		logic [HUE_W-1:0]        s_hue;
		logic [PCT_W-1:0]        s_sat;
		logic [PCT_W-1:0]        s_val;
		logic signed [HUE_W-1:0] d_hue;
		logic signed [PCT_W:0]   d_sat;
		logic signed [PCT_W:0]   d_val;
	} entry_t;

	typedef struct packed {
		logic             valid;
		logic [IDX_W-1:0] idx;
		logic             last;
	} tag_t;

	localparam int ENT_W = $bits(entry_t);

	// sequencer
	state_t             state_q;
	logic [IDX_W-1:0]   idx_q;
	logic [FRAME_W-1:0] frame_q;
	logic               ent_valid_q [PIXEL_COUNT];
	logic               adv;
	logic               issue;
	logic               wr_en;
	entry_t             wr_ent;
	logic [ENT_W-1:0]   rd_data;
	tag_t               tag_q [NSTAGE];

	assign adv   = !pixel.valid || pixel.ready;
	assign issue = (state_q == ST_WALK) && adv;
	assign q_pop = (state_q == ST_IDLE) && q_valid;
	assign wr_en = q_pop && (q_data.op == OP_LOAD);

	always_comb begin
		wr_ent.s_hue = q_data.s_hue;
		wr_ent.s_sat = q_data.s_sat;
		wr_ent.s_val = q_data.s_val;
		wr_ent.d_hue = q_data.d_hue;
		wr_ent.d_sat = q_data.d_sat;
		wr_ent.d_val = q_data.d_val;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
			for (int k = 0; k < PIXEL_COUNT; k++) begin
				ent_valid_q[k] <= 1'b0;
			end
		end else begin
			if (wr_en) begin
				ent_valid_q[q_data.idx[AW-1:0]] <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (q_pop && (q_data.op == OP_TICK)) begin
						idx_q   <= '0;
						state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					if (adv) begin
						if (idx_q == LAST_IDX) begin
							state_q <= ST_IDLE;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && (q_data.op == OP_TICK)) begin
			frame_q <= q_data.frame;
		end
	end

	hcf_ram #(
		.WIDTH (ENT_W),
		.DEPTH (PIXEL_COUNT)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (q_data.idx[AW-1:0]),
		.wr_data (wr_ent),
		.rd_en   (adv),
		.rd_addr (idx_q[AW-1:0]),
		.rd_data (rd_data)
	);

	// item tags move with the datapath, all stages freeze on a stalled output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NSTAGE; k++) begin
				tag_q[k] <= '0;
			end
		end else if (adv) begin
			tag_q[0] <= '{valid: issue, idx: idx_q, last: (idx_q == LAST_IDX)};
			for (int k = 1; k < NSTAGE; k++) begin
				tag_q[k] <= tag_q[k-1];
			end
		end
	end

	// datapath registers
	logic [FRAME_W-1:0]      frame_s1;
	logic                    ent_ok_s1;
	logic signed [N_W-1:0]   n_s2 [LANES];
	logic [M_W-1:0]          m_s3 [LANES];
	logic                    neg_s3 [LANES];
	logic [M_W-1:0]          m_s4 [LANES];
	logic                    neg_s4 [LANES];
	logic [Q_W-1:0]          qe_s4 [LANES];
	logic signed [N_W-1:0]   c_s5 [LANES];
	logic [HUE_W-1:0]        h_s6;
	logic [PCT_W-1:0]        s_s6;
	logic [V255_W-1:0]       v255_s6;
	logic [COLOR_W-1:0]      mx_s7;
	logic [PCT_W-1:0]        s_s7;
	sector_t                 sec_s7;
	logic [HMOD_W-1:0]       hmod_s7;
	logic [P_W-1:0]          p_s8;
	logic [COLOR_W-1:0]      mx_s8;
	sector_t                 sec_s8;
	logic [HMOD_W-1:0]       hmod_s8;
	logic [COLOR_W-1:0]      mx_s9;
	logic [COLOR_W-1:0]      mn_s9;
	sector_t                 sec_s9;
	logic [HMOD_W-1:0]       hmod_s9;
	logic [P2_W-1:0]         p2_s10;
	logic [COLOR_W-1:0]      mx_s10;
	logic [COLOR_W-1:0]      mn_s10;
	sector_t                 sec_s10;
	logic [COLOR_W-1:0]      adj_s11;
	logic [COLOR_W-1:0]      mx_s11;
	logic [COLOR_W-1:0]      mn_s11;
	sector_t                 sec_s11;
	logic [COLOR_W-1:0]      red_q;
	logic [COLOR_W-1:0]      green_q;
	logic [COLOR_W-1:0]      blue_q;

	// stage logic
	entry_t                  ent;
	logic [HUE_W-1:0]        st [LANES];
	logic signed [HUE_W-1:0] dl [LANES];
	logic signed [N_W-1:0]   n_c [LANES];
	logic signed [N_W-1:0]   mag [LANES];
	logic [M_W-1:0]          m_c [LANES];
	logic [M_W+RCP_W-1:0]    rcp_prod [LANES];
	logic [M_W-1:0]          chk [LANES];
	logic [M_W-1:0]          rem [LANES];
	logic [Q_W-1:0]          qf [LANES];
	logic signed [N_W-1:0]   c_c [LANES];
	logic [HUE_W-1:0]        h_c;
	logic [PCT_W-1:0]        pct_c [2];
	logic [V255_W+DIV100_W-1:0] mx_prod;
	sector_t                 sec_c;
	logic [HUE_W-1:0]        sec_base;
	logic [P_W+DIV100_W-1:0] mn_prod;
	logic [P2_W+DIV60_W-1:0] adj_prod;
	logic [COLOR_W-1:0]      r_c;
	logic [COLOR_W-1:0]      g_c;
	logic [COLOR_W-1:0]      b_c;

	// s1 -> s2: n = start*F + delta*f, per channel
	always_comb begin
		ent   = ent_ok_s1 ? entry_t'(rd_data) : '0;
		st[0] = ent.s_hue;
		st[1] = HUE_W'(ent.s_sat);
		st[2] = HUE_W'(ent.s_val);
		dl[0] = ent.d_hue;
		dl[1] = HUE_W'(ent.d_sat);
		dl[2] = HUE_W'(ent.d_val);
		for (int l = 0; l < LANES; l++) begin
			n_c[l] = $signed(N_W'(st[l])) * $signed(N_W'(FADE_STEPS))
				+ N_W'(dl[l]) * $signed(N_W'(frame_s1));
		end
	end

	// s2 -> s3: sign and magnitude, m = 2|n| + F
	// s3 -> s4: quotient estimate from the reciprocal of 2F
	// s4 -> s5: one correction step, sign back on
	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			mag[l]      = n_s2[l][N_W-1] ? -n_s2[l] : n_s2[l];
			m_c[l]      = {mag[l][M_W-2:0], 1'b0} + M_W'(FADE_STEPS);
			rcp_prod[l] = (M_W+RCP_W)'(m_s3[l]) * (M_W+RCP_W)'(RCP);
			chk[l]      = M_W'(M_W'(qe_s4[l]) * M_W'(TWO_F));
			rem[l]      = m_s4[l] - chk[l];
			qf[l]       = (rem[l] >= M_W'(TWO_F)) ? qe_s4[l] + 1'b1 : qe_s4[l];
			c_c[l]      = neg_s4[l] ? -$signed(N_W'(qf[l])) : $signed(N_W'(qf[l]));
		end
	end

	// s5 -> s6: hue wrap, percent clamp, v*255
	always_comb begin
		if (c_s5[0] < 0) begin
			h_c = HUE_W'(c_s5[0] + N_W'(HUE_FULL));
		end else if (c_s5[0] >= N_W'(HUE_FULL)) begin
			h_c = HUE_W'(c_s5[0] - N_W'(HUE_FULL));
		end else begin
			h_c = HUE_W'(c_s5[0]);
		end
		for (int l = 0; l < 2; l++) begin
			if (c_s5[l+1] < 0) begin
				pct_c[l] = '0;
			end else if (c_s5[l+1] > N_W'(PCT_MAX)) begin
				pct_c[l] = PCT_W'(PCT_MAX);
			end else begin
				pct_c[l] = PCT_W'(c_s5[l+1]);
			end
		end
	end

	// s6 -> s7: max = v*255/100, sector and offset within it
	always_comb begin
		mx_prod = (V255_W+DIV100_W)'(v255_s6) * (V255_W+DIV100_W)'(DIV100_MUL);
		priority if (h_s6 >= HUE_W'(5 * SECTOR_DEG)) begin
			sec_c    = SEC_MAG_RED;
			sec_base = HUE_W'(5 * SECTOR_DEG);
		end else if (h_s6 >= HUE_W'(4 * SECTOR_DEG)) begin
			sec_c    = SEC_BLU_MAG;
			sec_base = HUE_W'(4 * SECTOR_DEG);
		end else if (h_s6 >= HUE_W'(3 * SECTOR_DEG)) begin
			sec_c    = SEC_CYN_BLU;
			sec_base = HUE_W'(3 * SECTOR_DEG);
		end else if (h_s6 >= HUE_W'(2 * SECTOR_DEG)) begin
			sec_c    = SEC_GRN_CYN;
			sec_base = HUE_W'(2 * SECTOR_DEG);
		end else if (h_s6 >= HUE_W'(SECTOR_DEG)) begin
			sec_c    = SEC_YEL_GRN;
			sec_base = HUE_W'(SECTOR_DEG);
		end else begin
			sec_c    = SEC_RED_YEL;
			sec_base = '0;
		end
	end

	// s8 -> s9 min, s10 -> s11 adj, s11 -> out sector select
	always_comb begin
		mn_prod  = (P_W+DIV100_W)'(p_s8) * (P_W+DIV100_W)'(DIV100_MUL);
		adj_prod = (P2_W+DIV60_W)'(p2_s10) * (P2_W+DIV60_W)'(DIV60_MUL);
		unique case (sec_s11)
			SEC_RED_YEL: begin
				r_c = mx_s11;
				g_c = mn_s11 + adj_s11;
				b_c = mn_s11;
			end
			SEC_YEL_GRN: begin
				r_c = mx_s11 - adj_s11;
				g_c = mx_s11;
				b_c = mn_s11;
			end
			SEC_GRN_CYN: begin
				r_c = mn_s11;
				g_c = mx_s11;
				b_c = mn_s11 + adj_s11;
			end
			SEC_CYN_BLU: begin
				r_c = mn_s11;
				g_c = mx_s11 - adj_s11;
				b_c = mx_s11;
			end
			SEC_BLU_MAG: begin
				r_c = mn_s11 + adj_s11;
				g_c = mn_s11;
				b_c = mx_s11;
			end
			default: begin
				r_c = mx_s11;
				g_c = mn_s11;
				b_c = mx_s11 - adj_s11;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			frame_s1  <= frame_q;
			ent_ok_s1 <= ent_valid_q[idx_q[AW-1:0]];
			for (int l = 0; l < LANES; l++) begin
				n_s2[l]   <= n_c[l];
				m_s3[l]   <= m_c[l];
				neg_s3[l] <= n_s2[l][N_W-1];
				m_s4[l]   <= m_s3[l];
				neg_s4[l] <= neg_s3[l];
				qe_s4[l]  <= rcp_prod[l][RCP_SHIFT +: Q_W];
				c_s5[l]   <= c_c[l];
			end
			h_s6    <= h_c;
			s_s6    <= pct_c[0];
			v255_s6 <= V255_W'({pct_c[1], 8'b0}) - V255_W'(pct_c[1]);
			mx_s7   <= mx_prod[DIV100_SHIFT +: COLOR_W];
			s_s7    <= s_s6;
			sec_s7  <= sec_c;
			hmod_s7 <= HMOD_W'(h_s6 - sec_base);
			p_s8    <= P_W'(mx_s7) * P_W'(PCT_W'(PCT_MAX) - s_s7);
			mx_s8   <= mx_s7;
			sec_s8  <= sec_s7;
			hmod_s8 <= hmod_s7;
			mn_s9   <= mn_prod[DIV100_SHIFT +: COLOR_W];
			mx_s9   <= mx_s8;
			sec_s9  <= sec_s8;
			hmod_s9 <= hmod_s8;
			p2_s10  <= P2_W'(mx_s9 - mn_s9) * P2_W'(hmod_s9);
			mx_s10  <= mx_s9;
			mn_s10  <= mn_s9;
			sec_s10 <= sec_s9;
			adj_s11 <= adj_prod[DIV60_SHIFT +: COLOR_W];
			mx_s11  <= mx_s10;
			mn_s11  <= mn_s10;
			sec_s11 <= sec_s10;
			red_q   <= r_c;
			green_q <= g_c;
			blue_q  <= b_c;
		end
	end

	assign pixel.valid       = tag_q[NSTAGE-1].valid;
	assign pixel.pixel_index = tag_q[NSTAGE-1].idx;
	assign pixel.last_pixel  = tag_q[NSTAGE-1].last;
	assign pixel.red         = red_q;
	assign pixel.green       = green_q;
	assign pixel.blue        = blue_q;

	`HCF_ASSERT_IMPL(a_walk_in_range, clk, arst_n, state_q == ST_WALK, idx_q <= LAST_IDX, "walk index past strip")
	`HCF_ASSERT_IMPL(a_last_is_end, clk, arst_n, pixel.valid && pixel.last_pixel, pixel.pixel_index == LAST_IDX, "last flag on wrong led")
	`HCF_ASSERT_IMPL(a_no_load_in_walk, clk, arst_n, wr_en, !issue, "store written during a walk")
endmodule

[rtl/hsv_crossfade_pixel_engine.sv]
// channel  modport  carries
// cmd      sink     load or tick item: opcode, led_index, from/to hsv, frame
// pixel    source   one rgb item per led on a tick, last_pixel on the final led
//
// a tick leaves the command queue, then one led a cycle is read from the color store
// while the pixel output is not stalled, each result passing the datapath registers;
// a load is written as it leaves the queue; the front takes an item every cycle while
// the QUEUE_DEPTH command queue has room, so loads queue up behind a running tick
// reset clears the per-led valid flags, so every led reads as black at once
// a stalled pixel output freezes the whole back-end pipeline and the led walk
module hsv_crossfade_pixel_engine import hcf_pkg::*; #(
	parameter int PIXEL_COUNT = PIXEL_COUNT_DEF,
	parameter int FADE_STEPS  = FADE_STEPS_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	hcf_cmd_if.sink   cmd,
	hcf_pix_if.source pixel
);
	// front to queue
	hcf_cmd_t q_wdata;
	logic     q_push;
	logic     q_full;

	// queue to back
	hcf_cmd_t q_rdata;
	logic     q_pop;
	logic     q_valid;

	// front: range fixes, hue path and deltas, frame saturation
	hcf_front #(
		.PIXEL_COUNT (PIXEL_COUNT),
		.FADE_STEPS  (FADE_STEPS)
	) u_front (
		.cmd    (cmd),
		.q_data (q_wdata),
		.q_push (q_push),
		.q_full (q_full)
	);

	// short command queue decoupling front and back
	hcf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_wdata),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_rdata),
		.not_empty (q_valid)
	);

	// back: color store, led walk, lerp and hsv to rgb pipeline
	hcf_back #(
		.PIXEL_COUNT (PIXEL_COUNT),
		.FADE_STEPS  (FADE_STEPS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_data  (q_rdata),
		.q_valid (q_valid),
		.q_pop   (q_pop),
		.pixel   (pixel)
	);
endmodule

[bench/tb.sv]
`timescale 1ns / 100ps

module tb;
	import hcf_pkg::*;

	localparam int LEDS         = PIXEL_COUNT_DEF;
	localparam int STEPS        = FADE_STEPS_DEF;
	localparam int COLOR_FULL   = 255;
	localparam int RANDOM_ITEMS = 308;
	localparam int PAUSE_AT     = 160;
	localparam int DRAIN_CYCLES = 120;
	localparam int QUIET_LIMIT  = 3000;
	localparam int SHOW_LIMIT   = 10;

	// one command item as the sender presents it
	typedef struct {
		hcf_op_t            op;
		logic [IDX_W-1:0]   led;
		logic [HUE_W-1:0]   from_hue;
		logic [PCT_W-1:0]   from_sat;
		logic [PCT_W-1:0]   from_val;
		logic [HUE_W-1:0]   to_hue;
		logic [PCT_W-1:0]   to_sat;
		logic [PCT_W-1:0]   to_val;
		logic [FRAME_W-1:0] frame;
	} fade_cmd_t;

	typedef struct packed {
		logic [IDX_W-1:0]   pixel_index;
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
		logic               last_pixel;
	} pixel_t;

	// directed row: a command plus, for some ticks, one led's color known by hand
	typedef struct {
		fade_cmd_t cmd;
		bit        known;
		pixel_t    known_pix;
	} fade_row_t;

	logic clk = 1'b0;
	logic arst_n;

	hcf_cmd_if cmd_bus();
	hcf_pix_if pix_bus();

	hsv_crossfade_pixel_engine DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_bus),
		.pixel  (pix_bus)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// per-led fade store as the block should hold it
	logic [HUE_W-1:0]        base_hue [LEDS];
	logic [PCT_W-1:0]        base_sat [LEDS];
	logic [PCT_W-1:0]        base_val [LEDS];
	logic signed [HUE_W-1:0] hue_span [LEDS];
	logic signed [PCT_W:0]   sat_span [LEDS];
	logic signed [PCT_W:0]   val_span [LEDS];

	pixel_t    pixels_due [$];
	fade_row_t directed [$];
	int        mismatches = 0;
	bit        calm = 1'b0;

	// mostly no gap, often a short one, now and then a long one
	function automatic int pause_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) return 0;
		if (r < 94) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic int clamp_pct(int x);
		if (x < 0) return 0;
		if (x > PCT_MAX) return PCT_MAX;
		return x;
	endfunction

	// start + span*f/STEPS, halves rounded away from zero
	function automatic int fade_round(int base, int span, int f);
		int n;
		n = base * STEPS + span * f;
		if (n >= 0) return (2 * n + STEPS) / (2 * STEPS);
		return -((-2 * n + STEPS) / (2 * STEPS));
	endfunction

	// a load: hue wrapped into the circle, percentages saturated, shortest hue way
	function automatic void store_fade(fade_cmd_t c);
		int fh, th, fs, ts, fv, tv;
		fh = c.from_hue % HUE_FULL;
		th = c.to_hue % HUE_FULL;
		fs = clamp_pct(c.from_sat);
		ts = clamp_pct(c.to_sat);
		fv = clamp_pct(c.from_val);
		tv = clamp_pct(c.to_val);
		base_hue[c.led] = HUE_W'(fh);
		base_sat[c.led] = PCT_W'(fs);
		base_val[c.led] = PCT_W'(fv);
		hue_span[c.led] = HUE_W'(((th - fh + HUE_FULL + HUE_HALF) % HUE_FULL) - HUE_HALF);
		sat_span[c.led] = (PCT_W+1)'(ts - fs);
		val_span[c.led] = (PCT_W+1)'(tv - fv);
	endfunction

	// color of one led at step f, six-sector integer conversion
	function automatic pixel_t shade_led(int j, int f);
		int h, s, v, mx, mn, adj, r, g, b;
		pixel_t p;
		h = fade_round(int'(base_hue[j]), int'(hue_span[j]), f);
		s = clamp_pct(fade_round(int'(base_sat[j]), int'(sat_span[j]), f));
		v = clamp_pct(fade_round(int'(base_val[j]), int'(val_span[j]), f));
		if (h < 0) h += HUE_FULL;
		if (h < 0) h = 0;
		h = h % HUE_FULL;
		mx = v * COLOR_FULL / PCT_MAX;
		mn = mx * (PCT_MAX - s) / PCT_MAX;
		adj = (mx - mn) * (h % SECTOR_DEG) / SECTOR_DEG;
		case (h / SECTOR_DEG)
			0: begin r = mx; g = mn + adj; b = mn; end
			1: begin r = mx - adj; g = mx; b = mn; end
			2: begin r = mn; g = mx; b = mn + adj; end
			3: begin r = mn; g = mx - adj; b = mx; end
			4: begin r = mn + adj; g = mn; b = mx; end
			default: begin r = mx; g = mn; b = mx - adj; end
		endcase
		p.pixel_index = IDX_W'(j);
		p.red = COLOR_W'(r);
		p.green = COLOR_W'(g);
		p.blue = COLOR_W'(b);
		p.last_pixel = (j == LEDS - 1);
		return p;
	endfunction

	// a tick: one expected pixel per led in order
	function automatic void queue_frame(int frame, bit known, pixel_t known_pix);
		int f;
		pixel_t p;
		f = (frame > STEPS) ? STEPS : frame;
		for (int j = 0; j < LEDS; j++) begin
			p = shade_led(j, f);
			if (known && j == int'(known_pix.pixel_index)) p = known_pix;
			pixels_due.push_back(p);
		end
	endfunction

	function automatic fade_row_t load_row(int led, int fh, int fs, int fv,
			int th, int ts, int tv);
		fade_row_t r;
		r.cmd = '{OP_LOAD, IDX_W'(led), HUE_W'(fh), PCT_W'(fs), PCT_W'(fv),
			HUE_W'(th), PCT_W'(ts), PCT_W'(tv), '0};
		r.known = 1'b0;
		r.known_pix = '0;
		return r;
	endfunction

	function automatic fade_row_t tick_row(int frame, bit known, pixel_t p);
		fade_row_t r;
		r.cmd = '{OP_TICK, '0, '0, '0, '0, '0, '0, '0, FRAME_W'(frame)};
		r.known = known;
		r.known_pix = p;
		return r;
	endfunction

	// in-range values most of the time, the two end values and over-range codes now and then
	function automatic int draw_pct();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return $urandom_range(PCT_MAX + 1, 127);
		if (r == 1) return ($urandom_range(0, 1) != 0) ? PCT_MAX : 0;
		return $urandom_range(0, PCT_MAX);
	endfunction

	function automatic int draw_hue();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return $urandom_range(HUE_FULL, 511);
		if (r == 1) return ($urandom_range(0, 1) != 0) ? HUE_FULL - 1 : 0;
		return $urandom_range(0, HUE_FULL - 1);
	endfunction

	function automatic fade_cmd_t random_cmd();
		fade_cmd_t c;
		c.op = ($urandom_range(0, 99) < 62) ? OP_LOAD : OP_TICK;
		c.led = IDX_W'($urandom_range(0, LEDS - 1));
		c.from_hue = HUE_W'(draw_hue());
		c.from_sat = PCT_W'(draw_pct());
		c.from_val = PCT_W'(draw_pct());
		// some fades stay close to the start so the rounding edges get hit
		if ($urandom_range(0, 3) == 0) begin
			c.to_hue = HUE_W'((c.from_hue + $urandom_range(0, 4)) % 512);
			c.to_sat = c.from_sat ^ PCT_W'($urandom_range(0, 1));
			c.to_val = c.from_val ^ PCT_W'($urandom_range(0, 1));
		end else begin
			c.to_hue = HUE_W'(draw_hue());
			c.to_sat = PCT_W'(draw_pct());
			c.to_val = PCT_W'(draw_pct());
		end
		c.frame = FRAME_W'(($urandom_range(0, 7) == 0) ? $urandom_range(STEPS + 1, 255)
			: $urandom_range(0, STEPS));
		return c;
	endfunction

	function automatic void report_mismatch(string what, int led, int want, int got);
		mismatches++;
		if (mismatches <= SHOW_LIMIT)
			$display("%0t: led %0d %s expected %0d, got %0d", $realtime, led, what,
				want, got);
	endfunction

	// present one item from the falling edge until a rising edge takes it
	task automatic issue_cmd(input fade_cmd_t c, input bit known, input pixel_t known_pix);
		@(negedge clk);
		cmd_bus.valid     <= 1'b1;
		cmd_bus.opcode    <= c.op;
		cmd_bus.led_index <= c.led;
		cmd_bus.from_hue  <= c.from_hue;
		cmd_bus.from_sat  <= c.from_sat;
		cmd_bus.from_val  <= c.from_val;
		cmd_bus.to_hue    <= c.to_hue;
		cmd_bus.to_sat    <= c.to_sat;
		cmd_bus.to_val    <= c.to_val;
		cmd_bus.frame     <= c.frame;
		@(posedge clk);
		while (!cmd_bus.ready) @(posedge clk);
		if (c.op == OP_LOAD) store_fade(c);
		else queue_frame(c.frame, known, known_pix);
	endtask

	task automatic idle_cmd(input int n);
		if (n > 0) begin
			@(negedge clk);
			cmd_bus.valid <= 1'b0;
			repeat (n - 1) @(negedge clk);
		end
	endtask

	// pixel sink: random back-pressure, none while calm
	initial begin : pixel_sink
		int stall;
		stall = 0;
		pix_bus.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall > 0) begin
				pix_bus.ready <= 1'b0;
				stall--;
			end else begin
				pix_bus.ready <= 1'b1;
				stall = calm ? 0 : pause_len();
			end
		end
	end

	// every accepted pixel against the oldest expected one
	always @(posedge clk) begin : pixel_check
		pixel_t want;
		if (arst_n && pix_bus.valid && pix_bus.ready) begin
			if (pixels_due.size() == 0) begin
				report_mismatch("unexpected item", pix_bus.pixel_index, 0, 1);
			end else begin
				want = pixels_due.pop_front();
				if (pix_bus.pixel_index !== want.pixel_index)
					report_mismatch("pixel_index", want.pixel_index, want.pixel_index,
						pix_bus.pixel_index);
				if (pix_bus.red !== want.red)
					report_mismatch("red", want.pixel_index, want.red, pix_bus.red);
				if (pix_bus.green !== want.green)
					report_mismatch("green", want.pixel_index, want.green, pix_bus.green);
				if (pix_bus.blue !== want.blue)
					report_mismatch("blue", want.pixel_index, want.blue, pix_bus.blue);
				if (pix_bus.last_pixel !== want.last_pixel)
					report_mismatch("last_pixel", want.pixel_index, want.last_pixel,
						pix_bus.last_pixel);
			end
		end
	end

	// ends a hung run: too long without an item moving on either side
	initial begin : watchdog
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < QUIET_LIMIT) begin
			@(posedge clk);
			if ((cmd_bus.valid && cmd_bus.ready) || (pix_bus.valid && pix_bus.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("watchdog: no item moved for %0d cycles", QUIET_LIMIT);
		$display("DONE: errors detected");
		$finish;
	end

	initial begin : stimulus
		arst_n = 1'b0;
		cmd_bus.valid = 1'b0;
		cmd_bus.opcode = OP_LOAD;
		cmd_bus.led_index = '0;
		cmd_bus.from_hue = '0;
		cmd_bus.from_sat = '0;
		cmd_bus.from_val = '0;
		cmd_bus.to_hue = '0;
		cmd_bus.to_sat = '0;
		cmd_bus.to_val = '0;
		cmd_bus.frame = '0;
		for (int j = 0; j < LEDS; j++) begin
			base_hue[j] = '0;
			base_sat[j] = '0;
			base_val[j] = '0;
			hue_span[j] = '0;
			sat_span[j] = '0;
			val_span[j] = '0;
		end

		// store is black after reset, at the first and the last frame code
		directed.push_back(tick_row(0, 1'b1, '{6'd0, 8'd0, 8'd0, 8'd0, 1'b0}));
		directed.push_back(tick_row(255, 1'b1, '{6'd63, 8'd0, 8'd0, 8'd0, 1'b1}));
		// full red held still
		directed.push_back(load_row(0, 0, 100, 100, 0, 100, 100));
		directed.push_back(tick_row(0, 1'b1, '{6'd0, 8'd255, 8'd0, 8'd0, 1'b0}));
		// last led, green to blue, read at the end of the fade
		directed.push_back(load_row(63, 120, 100, 100, 240, 100, 100));
		directed.push_back(tick_row(32, 1'b1, '{6'd63, 8'd0, 8'd0, 8'd255, 1'b1}));
		// over-range inputs: hue 511 wraps to 151, sat and val saturate to 100
		directed.push_back(load_row(0, 511, 127, 127, 359, 0, 0));
		directed.push_back(tick_row(0, 1'b1, '{6'd0, 8'd0, 8'd255, 8'd131, 1'b0}));
		// frame just past the end counts as the end: value 0 gives black
		directed.push_back(tick_row(33, 1'b1, '{6'd0, 8'd0, 8'd0, 8'd0, 1'b0}));
		directed.push_back(tick_row(16, 1'b0, '0));
		// half-circle hue, one-degree wraps both ways, half-step rounding
		directed.push_back(load_row(1, 0, 100, 100, 180, 100, 100));
		directed.push_back(load_row(2, 359, 50, 50, 0, 50, 49));
		directed.push_back(load_row(3, 0, 0, 0, 359, 100, 100));
		directed.push_back(load_row(4, 360, 101, 100, 480, 127, 0));
		directed.push_back(load_row(5, 300, 100, 100, 60, 100, 100));
		directed.push_back(load_row(62, 359, 100, 100, 359, 100, 100));
		directed.push_back(tick_row(16, 1'b0, '0));
		directed.push_back(tick_row(1, 1'b0, '0));
		directed.push_back(tick_row(31, 1'b0, '0));
		directed.push_back(tick_row(255, 1'b0, '0));
		// led 1 went the long way to 180: cyan
		directed.push_back(tick_row(32, 1'b1, '{6'd1, 8'd0, 8'd255, 8'd255, 1'b0}));

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed[i]) begin
			issue_cmd(directed[i].cmd, directed[i].known, directed[i].known_pix);
			idle_cmd(pause_len());
		end

		for (int k = 0; k < RANDOM_ITEMS; k++) begin
			// a fixed calm stretch plus random ones
			if (k % 50 == 0) calm = (k == 100) || ($urandom_range(0, 3) == 0);
			// sender holds off until the block has drained completely
			if (k == PAUSE_AT) begin
				idle_cmd(1);
				while (pixels_due.size() != 0) @(posedge clk);
			end
			issue_cmd(random_cmd(), 1'b0, '0);
			if (!calm) idle_cmd(pause_len());
		end

		idle_cmd(1);
		while (pixels_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
